/* hdl/y86_instruction_executor_macros.svh */
// Assertion macros for the Y86 instruction executor.
// Used by the top level only; needs no other file.
`ifndef Y86_INSTRUCTION_EXECUTOR_MACROS_SVH
`define Y86_INSTRUCTION_EXECUTOR_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define Y86_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Condition never holds.
`define Y86_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");

`endif

/* hdl/y86_pkg.sv */
// Shared types and constants of the Y86 instruction executor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package y86_pkg;

   localparam int REG_COUNT = 8;
   localparam logic [2:0] SP_REG = 3'd4;

   // Run status codes
   localparam logic [2:0] ST_OK  = 3'd0;
   localparam logic [2:0] ST_HLT = 3'd1;
   localparam logic [2:0] ST_ADR = 3'd2;
   localparam logic [2:0] ST_INS = 3'd3;
   localparam logic [2:0] ST_OVF = 3'd4;
   localparam logic [2:0] ST_FIN = 3'd5;

   // Item actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_EXEC  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_CODE_START = 1'b0;
   localparam logic CSR_CODE_END   = 1'b1;

   // Opcodes
   localparam logic [7:0] OP_NOP    = 8'h00;
   localparam logic [7:0] OP_HALT   = 8'h10;
   localparam logic [7:0] OP_RRMOVL = 8'h20;
   localparam logic [7:0] OP_IRMOVL = 8'h30;
   localparam logic [7:0] OP_RMMOVL = 8'h40;
   localparam logic [7:0] OP_MRMOVL = 8'h50;
   localparam logic [7:0] OP_ADDL   = 8'h60;
   localparam logic [7:0] OP_SUBL   = 8'h61;
   localparam logic [7:0] OP_ANDL   = 8'h62;
   localparam logic [7:0] OP_XORL   = 8'h63;
   localparam logic [7:0] OP_MULL   = 8'h64;
   localparam logic [7:0] OP_CMPL   = 8'h65;
   localparam logic [7:0] OP_JMP    = 8'h70;
   localparam logic [7:0] OP_JLE    = 8'h71;
   localparam logic [7:0] OP_JL     = 8'h72;
   localparam logic [7:0] OP_JE     = 8'h73;
   localparam logic [7:0] OP_JNE    = 8'h74;
   localparam logic [7:0] OP_JGE    = 8'h75;
   localparam logic [7:0] OP_JG     = 8'h76;
   localparam logic [7:0] OP_CALL   = 8'h80;
   localparam logic [7:0] OP_RET    = 8'h90;
   localparam logic [7:0] OP_PUSHL  = 8'ha0;
   localparam logic [7:0] OP_POPL   = 8'hb0;
   localparam logic [7:0] OP_READB  = 8'hc0;
   localparam logic [7:0] OP_READL  = 8'hc1;
   localparam logic [7:0] OP_WRITEB = 8'hd0;
   localparam logic [7:0] OP_WRITEL = 8'hd1;
   localparam logic [7:0] OP_MOVSBL = 8'he0;

   typedef struct packed {
      logic [1:0]         action;
      logic [11:0]        load_address;
      logic [7:0]         load_byte;
      logic signed [31:0] input_value;
      logic               input_present;
   } y86_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [11:0]        program_counter;
      logic               out_valid;
      logic               out_is_byte;
      logic signed [31:0] out_value;
      logic               zero_flag;
      logic               sign_flag;
      logic               overflow_flag;
   } y86_rsp_type;

   typedef enum logic [1:0] {
      CLS_LOAD  = 2'd0,
      CLS_START = 2'd1,
      CLS_EXEC  = 2'd2,
      CLS_NONE  = 2'd3
   } y86_cls_type;

   typedef struct packed {
      y86_cls_type cls;
      y86_req_type req;
   } y86_entry_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } y86_qctl_type;

   typedef struct packed {
      logic [11:0] code_start;
      logic [11:0] code_end;
   } y86_cfg_type;

endpackage

`default_nettype wire

/* hdl/y86_front.sv */
// Front end: accepts transactions, classifies them and queues them.
// Depends on y86_pkg.
`timescale 1ns / 1ps
`default_nettype none

module y86_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire y86_pkg::y86_req_type   req_data,
   input  wire y86_pkg::y86_qctl_type  qctl,
   output logic                        q_valid,
   output y86_pkg::y86_entry_type      q_entry
);

   y86_pkg::y86_entry_type q_ff [2];
   y86_pkg::y86_entry_type q_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // Classify the incoming transaction
   always_comb begin
      q_in.req = req_data;
      case (req_data.action)
         y86_pkg::ACT_LOAD:  q_in.cls = y86_pkg::CLS_LOAD;
         y86_pkg::ACT_START: q_in.cls = y86_pkg::CLS_START;
         y86_pkg::ACT_EXEC:  q_in.cls = y86_pkg::CLS_EXEC;
         default:            q_in.cls = y86_pkg::CLS_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2) && !qctl.clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_entry   = q_ff[rp_ff];

   // Advance pointers and fill count
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = qctl.pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, qctl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/y86_back.sv */
// Back end: instruction sequencer with byte memory, register file and result register.
// Depends on y86_pkg.
`timescale 1ns / 1ps
`default_nettype none

module y86_back #(
   parameter int MEM_BYTES = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire y86_pkg::y86_cfg_type   cfg,
   input  wire logic                   q_valid,
   input  wire y86_pkg::y86_entry_type q_entry,
   output y86_pkg::y86_qctl_type       qctl,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output y86_pkg::y86_rsp_type        rsp_data
);

   localparam int AW = $clog2(MEM_BYTES);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_FETCH = 8'b0000_0010,
      S_REGRD = 8'b0000_0100,
      S_EXEC  = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_RDATA = 8'b0010_0000,
      S_WDATA = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } y86_state_type;

   logic [7:0]  mem [MEM_BYTES];
   logic [31:0] rf [y86_pkg::REG_COUNT];

   y86_state_type          state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   clr_done_ff, clr_done_in;
   logic [AW-1:0]          pc_ff, pc_in;
   logic [2:0]             status_ff, status_in;
   logic                   zf_ff, zf_in, sf_ff, sf_in, of_ff, of_in;
   y86_pkg::y86_entry_type cur_ff, cur_in;
   logic [7:0]             buf_ff [6];
   logic [7:0]             buf_in [6];
   logic [2:0]             cnt_ff, cnt_in;
   logic [31:0]            ra_ff, ra_in, rb_ff, rb_in, sp_ff, sp_in;
   logic [AW-1:0]          daddr_ff, daddr_in;
   logic [31:0]            wval_ff, wval_in, dval_ff, dval_in;
   logic                   byte_ff, byte_in;
   logic signed [63:0]     prod_ff, prod_in;
   logic                   dwe_ff, dwe_in;
   logic [2:0]             dsel_ff, dsel_in;
   logic [31:0]            dwv_ff, dwv_in;
   logic                   ov_ff, ov_in, ob_ff, ob_in;
   logic [31:0]            oval_ff, oval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   y86_pkg::y86_rsp_type   rsp_ff, rsp_in;
   logic [7:0]             mem_q_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0]    mem_wd;
   logic          rf_we;
   logic [2:0]    rf_wa;
   logic [31:0]   rf_wd;

   logic [7:0]  op;
   logic [3:0]  ha, lb;
   logic [31:0] disp, tgt, cs32, ce32, pc32, la32;
   logic [31:0] alu_v, logic_v, ea_lb, ea_ha, sp_dec, sp_inc, in_v;
   logic        alu_ovf, take, out_free, nib_bad;
   logic [2:0]  last;
   logic [1:0]  bidx;

   // Decode the fetched bytes
   assign op      = buf_ff[0];
   assign ha      = buf_ff[1][7:4];
   assign lb      = buf_ff[1][3:0];
   assign disp    = {buf_ff[5], buf_ff[4], buf_ff[3], buf_ff[2]};
   assign tgt     = {buf_ff[4], buf_ff[3], buf_ff[2], buf_ff[1]};
   assign cs32    = {20'd0, cfg.code_start};
   assign ce32    = {20'd0, cfg.code_end};
   assign pc32    = {{(32-AW){1'b0}}, pc_ff};
   assign la32    = {20'd0, cur_ff.req.load_address};
   assign ea_lb   = disp + rb_ff;
   assign ea_ha   = disp + ra_ff;
   assign sp_dec  = sp_ff - 32'd4;
   assign sp_inc  = sp_ff + 32'd4;
   assign in_v    = cur_ff.req.input_value;
   assign last    = byte_ff ? 3'd1 : 3'd4;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Shared adder with signed overflow, and logic unit
   always_comb begin
      if (op == y86_pkg::OP_ADDL) begin
         alu_v   = rb_ff + ra_ff;
         alu_ovf = (ra_ff[31] == rb_ff[31]) && (alu_v[31] != rb_ff[31]);
      end else begin
         alu_v   = rb_ff - ra_ff;
         alu_ovf = (ra_ff[31] != rb_ff[31]) && (alu_v[31] != rb_ff[31]);
      end
      logic_v = (op == y86_pkg::OP_ANDL) ? (rb_ff & ra_ff) : (rb_ff ^ ra_ff);
   end

   // Branch condition
   always_comb begin
      case (op)
         y86_pkg::OP_JMP: take = 1'b1;
         y86_pkg::OP_JLE: take = (sf_ff ^ of_ff) || zf_ff;
         y86_pkg::OP_JL:  take = sf_ff ^ of_ff;
         y86_pkg::OP_JE:  take = zf_ff;
         y86_pkg::OP_JNE: take = !zf_ff;
         y86_pkg::OP_JGE: take = !(sf_ff ^ of_ff);
         default:         take = !(sf_ff ^ of_ff) && !zf_ff;
      endcase
   end

   // Operand check per instruction class
   always_comb begin
      case (op) inside
         y86_pkg::OP_RRMOVL, y86_pkg::OP_RMMOVL, y86_pkg::OP_MRMOVL, y86_pkg::OP_MOVSBL,
         [y86_pkg::OP_ADDL:y86_pkg::OP_CMPL]:
            nib_bad = ha[3] || lb[3];
         y86_pkg::OP_IRMOVL:
            nib_bad = (ha != 4'hf) || lb[3];
         y86_pkg::OP_PUSHL, y86_pkg::OP_POPL, y86_pkg::OP_READB, y86_pkg::OP_READL,
         y86_pkg::OP_WRITEB, y86_pkg::OP_WRITEL:
            nib_bad = ha[3] || (lb != 4'hf);
         [y86_pkg::OP_JMP:y86_pkg::OP_JG], y86_pkg::OP_CALL:
            nib_bad = (tgt < cs32) || (tgt > ce32);
         default:
            nib_bad = 1'b0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_done_in  = clr_done_ff;
      pc_in        = pc_ff;
      status_in    = status_ff;
      zf_in        = zf_ff;
      sf_in        = sf_ff;
      of_in        = of_ff;
      cur_in       = cur_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      sp_in        = sp_ff;
      daddr_in     = daddr_ff;
      wval_in      = wval_ff;
      dval_in      = dval_ff;
      byte_in      = byte_ff;
      prod_in      = prod_ff;
      dwe_in       = dwe_ff;
      dsel_in      = dsel_ff;
      dwv_in       = dwv_ff;
      ov_in        = ov_ff;
      ob_in        = ob_ff;
      oval_in      = oval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      qctl.pop     = 1'b0;
      qctl.clearing = !clr_done_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_ff;
      mem_wd       = 8'd0;
      mem_ra       = pc_ff + AW'(cnt_ff);
      rf_we        = 1'b0;
      rf_wa        = y86_pkg::SP_REG;
      rf_wd        = 32'd0;
      bidx         = 2'(cnt_ff - 3'd1);

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Clear memory after reset
      if (!clr_done_ff) begin
         mem_we = 1'b1;
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(MEM_BYTES - 1)) begin
            clr_done_in = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid && clr_done_ff) begin
               qctl.pop = 1'b1;
               cur_in   = q_entry;
               dwe_in   = 1'b0;
               ov_in    = 1'b0;
               ob_in    = 1'b0;
               oval_in  = 32'd0;
               cnt_in   = 3'd0;
               state_in = S_DONE;
               case (q_entry.cls)
                  y86_pkg::CLS_LOAD: begin
                     mem_we = 1'b1;
                     mem_wa = AW'({20'd0, q_entry.req.load_address});
                     mem_wd = q_entry.req.load_byte;
                  end
                  y86_pkg::CLS_START: begin
                     pc_in     = cs32[AW-1:0];
                     status_in = y86_pkg::ST_OK;
                  end
                  y86_pkg::CLS_EXEC: begin
                     if (status_ff == y86_pkg::ST_OK) begin
                        if (pc32 >= ce32) begin
                           status_in = y86_pkg::ST_FIN;
                        end else if (pc32 < cs32) begin
                           status_in = y86_pkg::ST_ADR;
                        end else begin
                           state_in = S_FETCH;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FETCH: begin
            if (cnt_ff != 3'd0) begin
               buf_in[cnt_ff - 3'd1] = mem_q_ff;
            end
            if (cnt_ff == 3'd6) begin
               state_in = S_REGRD;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         S_REGRD: begin
            ra_in    = rf[ha[2:0]];
            rb_in    = rf[lb[2:0]];
            sp_in    = rf[y86_pkg::SP_REG];
            state_in = S_EXEC;
         end

         S_EXEC: begin
            cnt_in   = 3'd0;
            dval_in  = 32'd0;
            byte_in  = 1'b0;
            state_in = S_DONE;
            if (nib_bad) begin
               status_in = y86_pkg::ST_ADR;
            end else begin
               case (op)
                  y86_pkg::OP_NOP: pc_in = pc_ff + AW'(1);
                  y86_pkg::OP_HALT: status_in = y86_pkg::ST_HLT;
                  y86_pkg::OP_RRMOVL: begin
                     dwe_in  = 1'b1;
                     dsel_in = lb[2:0];
                     dwv_in  = ra_ff;
                     pc_in   = pc_ff + AW'(2);
                  end
                  y86_pkg::OP_IRMOVL: begin
                     dwe_in  = 1'b1;
                     dsel_in = lb[2:0];
                     dwv_in  = disp;
                     pc_in   = pc_ff + AW'(6);
                  end
                  y86_pkg::OP_RMMOVL: begin
                     daddr_in = ea_lb[AW-1:0];
                     wval_in  = ra_ff;
                     pc_in    = pc_ff + AW'(6);
                     state_in = S_WDATA;
                  end
                  y86_pkg::OP_MRMOVL, y86_pkg::OP_MOVSBL: begin
                     daddr_in = ea_lb[AW-1:0];
                     byte_in  = (op == y86_pkg::OP_MOVSBL);
                     pc_in    = pc_ff + AW'(6);
                     state_in = S_RDATA;
                  end
                  y86_pkg::OP_ADDL, y86_pkg::OP_SUBL, y86_pkg::OP_CMPL: begin
                     if (alu_ovf) begin
                        zf_in     = 1'b0;
                        sf_in     = 1'b0;
                        of_in     = 1'b1;
                        status_in = y86_pkg::ST_OVF;
                     end else begin
                        zf_in   = (alu_v == 32'd0);
                        sf_in   = alu_v[31];
                        of_in   = 1'b0;
                        dwe_in  = (op != y86_pkg::OP_CMPL);
                        dsel_in = lb[2:0];
                        dwv_in  = alu_v;
                        pc_in   = pc_ff + AW'(2);
                     end
                  end
                  y86_pkg::OP_ANDL, y86_pkg::OP_XORL: begin
                     zf_in   = (logic_v == 32'd0);
                     sf_in   = logic_v[31];
                     of_in   = 1'b0;
                     dwe_in  = 1'b1;
                     dsel_in = lb[2:0];
                     dwv_in  = logic_v;
                     pc_in   = pc_ff + AW'(2);
                  end
                  y86_pkg::OP_MULL: begin
                     prod_in  = $signed(rb_ff) * $signed(ra_ff);
                     state_in = S_MUL;
                  end
                  y86_pkg::OP_JMP, y86_pkg::OP_JLE, y86_pkg::OP_JL, y86_pkg::OP_JE,
                  y86_pkg::OP_JNE, y86_pkg::OP_JGE, y86_pkg::OP_JG: begin
                     pc_in = take ? tgt[AW-1:0] : pc_ff + AW'(5);
                  end
                  y86_pkg::OP_CALL: begin
                     rf_we    = 1'b1;
                     rf_wd    = sp_dec;
                     daddr_in = sp_dec[AW-1:0];
                     wval_in  = {{(32-AW){1'b0}}, pc_ff + AW'(5)};
                     pc_in    = tgt[AW-1:0];
                     state_in = S_WDATA;
                  end
                  y86_pkg::OP_RET, y86_pkg::OP_POPL: begin
                     rf_we    = 1'b1;
                     rf_wd    = sp_inc;
                     daddr_in = sp_ff[AW-1:0];
                     if (op == y86_pkg::OP_POPL) begin
                        pc_in = pc_ff + AW'(2);
                     end
                     state_in = S_RDATA;
                  end
                  y86_pkg::OP_PUSHL: begin
                     rf_we    = 1'b1;
                     rf_wd    = sp_dec;
                     daddr_in = sp_dec[AW-1:0];
                     wval_in  = ra_ff;
                     pc_in    = pc_ff + AW'(2);
                     state_in = S_WDATA;
                  end
                  y86_pkg::OP_READB, y86_pkg::OP_READL: begin
                     daddr_in = ea_ha[AW-1:0];
                     byte_in  = (op == y86_pkg::OP_READB);
                     if (!cur_ff.req.input_present) begin
                        zf_in = 1'b1;
                        pc_in = pc_ff + AW'(6);
                     end else if ((op == y86_pkg::OP_READB) &&
                                  ({{(32-AW){1'b0}}, ea_ha[AW-1:0]} < ce32)) begin
                        status_in = y86_pkg::ST_ADR;
                     end else begin
                        if (op == y86_pkg::OP_READB) begin
                           wval_in = {24'd0, in_v[7:0]};
                           zf_in   = (in_v[7:0] == 8'd0);
                        end else begin
                           wval_in = in_v;
                           zf_in   = (in_v == 32'd0);
                        end
                        pc_in    = pc_ff + AW'(6);
                        state_in = S_WDATA;
                     end
                  end
                  y86_pkg::OP_WRITEB, y86_pkg::OP_WRITEL: begin
                     daddr_in = ea_ha[AW-1:0];
                     byte_in  = (op == y86_pkg::OP_WRITEB);
                     pc_in    = pc_ff + AW'(6);
                     state_in = S_RDATA;
                  end
                  default: status_in = y86_pkg::ST_INS;
               endcase
            end
         end

         S_MUL: begin
            state_in = S_DONE;
            if ((prod_ff[63:31] != 33'd0) && (prod_ff[63:31] != {33{1'b1}})) begin
               zf_in     = 1'b0;
               sf_in     = 1'b0;
               of_in     = 1'b1;
               status_in = y86_pkg::ST_OVF;
            end else begin
               zf_in   = (prod_ff[31:0] == 32'd0);
               sf_in   = prod_ff[31];
               of_in   = 1'b0;
               dwe_in  = 1'b1;
               dsel_in = lb[2:0];
               dwv_in  = prod_ff[31:0];
               pc_in   = pc_ff + AW'(2);
            end
         end

         S_RDATA: begin
            mem_ra = daddr_ff + AW'(cnt_ff);
            if (cnt_ff != 3'd0) begin
               dval_in[8*bidx +: 8] = mem_q_ff;
            end
            if (cnt_ff == last) begin
               state_in = S_DONE;
               dsel_in  = ha[2:0];
               case (op)
                  y86_pkg::OP_MRMOVL, y86_pkg::OP_POPL: begin
                     dwe_in = 1'b1;
                     dwv_in = dval_in;
                  end
                  y86_pkg::OP_MOVSBL: begin
                     dwe_in = 1'b1;
                     dwv_in = {{24{dval_in[7]}}, dval_in[7:0]};
                  end
                  y86_pkg::OP_RET: pc_in = dval_in[AW-1:0];
                  default: begin
                     ov_in   = 1'b1;
                     ob_in   = byte_ff;
                     oval_in = dval_in;
                  end
               endcase
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         S_WDATA: begin
            mem_we = 1'b1;
            mem_wa = daddr_ff + AW'(cnt_ff);
            mem_wd = wval_ff[8*cnt_ff[1:0] +: 8];
            if (cnt_ff == last - 3'd1) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rf_we  = dwe_ff;
               rf_wa  = dsel_ff;
               rf_wd  = dwv_ff;
               dwe_in = 1'b0;
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.program_counter = pc32[11:0];
               rsp_in.out_valid       = ov_ff;
               rsp_in.out_is_byte     = ov_ff && ob_ff;
               rsp_in.out_value       = oval_ff;
               rsp_in.zero_flag       = zf_ff;
               rsp_in.sign_flag       = sf_ff;
               rsp_in.overflow_flag   = of_ff;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clr_ff       <= '0;
         clr_done_ff  <= 1'b0;
         pc_ff        <= '0;
         status_ff    <= y86_pkg::ST_OK;
         zf_ff        <= 1'b0;
         sf_ff        <= 1'b0;
         of_ff        <= 1'b0;
         dwe_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_done_ff  <= clr_done_in;
         pc_ff        <= pc_in;
         status_ff    <= status_in;
         zf_ff        <= zf_in;
         sf_ff        <= sf_in;
         of_ff        <= of_in;
         dwe_ff       <= dwe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      buf_ff   <= buf_in;
      cnt_ff   <= cnt_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      sp_ff    <= sp_in;
      daddr_ff <= daddr_in;
      wval_ff  <= wval_in;
      dval_ff  <= dval_in;
      byte_ff  <= byte_in;
      prod_ff  <= prod_in;
      dsel_ff  <= dsel_in;
      dwv_ff   <= dwv_in;
      ov_ff    <= ov_in;
      ob_ff    <= ob_in;
      oval_ff  <= oval_in;
      rsp_ff   <= rsp_in;
   end

   // Byte memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < y86_pkg::REG_COUNT; i++) begin
            rf[i] <= 32'd0;
         end
      end else if (rf_we) begin
         rf[rf_wa] <= rf_wd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hdl/y86_instruction_executor.sv */
// Y86 instruction executor top level: configuration registers, front queue and back end.
// Depends on y86_pkg, y86_front, y86_back and the assertion macro header.
//
// Usage: each transaction on req_* is one item: load a memory byte, restart at
// code_start, or execute one instruction. Each item yields exactly one result on
// rsp_*, in order. csr_write with csr_index selects code_start or code_end.
// Sequence: load, restart and no-op items go from S_IDLE straight to S_DONE in the
// back end; an executed instruction passes S_FETCH, S_REGRD and S_EXEC, then S_RDATA
// for a data read, S_WDATA for a data write or S_MUL for mull, then S_DONE. The byte
// memory has a single read and a single write port, so instruction fetch (six bytes)
// and the data access are serial; the back end takes the next item only from S_IDLE.
// A two-entry queue separates acceptance from execution, and a result register
// holds a finished result while the next item is taken in.
// After reset the memory is cleared one byte a cycle, all MEM_BYTES bytes
// (4096 by default); req_ready stays low until then. When the receiver stalls
// rsp_valid holds, the back end waits and, once the queue fills, req_ready drops.
// MEM_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
`include "y86_instruction_executor_macros.svh"

module y86_instruction_executor #(
   parameter int MEM_BYTES = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire y86_pkg::y86_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output y86_pkg::y86_rsp_type      rsp_data,
   input  wire logic                 csr_write,
   input  wire logic                 csr_index,
   input  wire logic [11:0]          csr_wdata
);

   logic [11:0]            code_start_ff, code_start_in;
   logic [11:0]            code_end_ff, code_end_in;
   y86_pkg::y86_cfg_type   cfg;
   y86_pkg::y86_qctl_type  qctl;
   y86_pkg::y86_entry_type q_entry;
   logic                   q_valid;

   // Update configuration
   always_comb begin
      code_start_in = code_start_ff;
      code_end_in   = code_end_ff;
      if (csr_write) begin
         case (csr_index)
            y86_pkg::CSR_CODE_START: code_start_in = csr_wdata;
            y86_pkg::CSR_CODE_END:   code_end_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_start_ff <= 12'd0;
         code_end_ff   <= 12'd0;
      end else begin
         code_start_ff <= code_start_in;
         code_end_ff   <= code_end_in;
      end
   end

   assign cfg.code_start = code_start_ff;
   assign cfg.code_end   = code_end_ff;

   y86_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qctl      (qctl),
      .q_valid   (q_valid),
      .q_entry   (q_entry)
   );

   y86_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .qctl      (qctl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Checks
   `Y86_ASSERT_NEVER(a_no_accept_clear, clock, reset, qctl.clearing && req_valid && req_ready)
   `Y86_ASSERT_IMPLY(a_pop_has_item, clock, reset, qctl.pop, q_valid && !qctl.clearing)
   `Y86_ASSERT_IMPLY(a_status_range, clock, reset, rsp_valid, rsp_data.status <= y86_pkg::ST_FIN)
   `Y86_ASSERT_IMPLY(a_out_byte, clock, reset, rsp_valid && !rsp_data.out_valid, rsp_data.out_value == 32'd0)

endmodule

`default_nettype wire

/* dv/y86_instruction_executor_tb.sv */
// Self-checking testbench for the Y86 instruction executor: directed cases, then random programs.
// Depends on y86_pkg and the y86_instruction_executor RTL.
`timescale 1ns / 1ps

module y86_instruction_executor_tb;
   import y86_pkg::*;

   localparam int MEM_SIZE   = 4096;
   localparam int STALL_MAX  = 20000;
   localparam int DRAIN_WAIT = 40;
   localparam int ITEM_GOAL  = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   y86_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   y86_rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_CODE_START;
   logic [11:0] csr_wdata = '0;

   // Model of the core state
   logic [7:0]  mem_image [MEM_SIZE];
   logic [31:0] reg_image [8];
   logic [11:0] pc_image;
   logic        zf_image, sf_image, of_image;
   logic [2:0]  status_image;
   logic [11:0] code_start_q, code_end_q;
   logic        out_valid_n, out_byte_n;
   logic [31:0] out_value_n;

   y86_rsp_type expected_results [$];
   logic [7:0]  program_bytes [$];
   int          instr_offsets [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   bit          idle_on = 1'b1;

   y86_instruction_executor i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] mem_rd8(logic [31:0] a);
      return mem_image[a[11:0]];
   endfunction

   function automatic logic [31:0] mem_rd32(logic [31:0] a);
      return {mem_rd8(a + 3), mem_rd8(a + 2), mem_rd8(a + 1), mem_rd8(a)};
   endfunction

   function automatic void mem_wr32(logic [31:0] a, logic [31:0] v);
      for (int i = 0; i < 4; i++) mem_image[(a + i) & 32'hfff] = v[8*i +: 8];
   endfunction

   // Execute one instruction at the program counter
   function automatic void execute_instr(y86_req_type r);
      logic [31:0]        pc, disp, tgt, addr, v;
      logic [7:0]         op, rb;
      logic [3:0]         ha, lb;
      logic [2:0]         hi, lo;
      logic signed [63:0] a64, b64, r64;
      logic               take;
      pc = {20'd0, pc_image};
      if (pc >= code_end_q) begin status_image = ST_FIN; return; end
      if (pc < code_start_q) begin status_image = ST_ADR; return; end
      op = mem_rd8(pc);
      rb = mem_rd8(pc + 1);
      ha = rb[7:4];
      lb = rb[3:0];
      disp = mem_rd32(pc + 2);
      tgt = mem_rd32(pc + 1);
      // decode checks
      case (op)
         OP_NOP: begin pc_image = pc + 1; return; end
         OP_HALT: begin status_image = ST_HLT; return; end
         OP_RRMOVL, OP_RMMOVL, OP_MRMOVL, OP_MOVSBL, OP_ADDL, OP_SUBL,
         OP_ANDL, OP_XORL, OP_MULL, OP_CMPL: begin
            if (ha[3] || lb[3]) begin status_image = ST_ADR; return; end
         end
         OP_IRMOVL: begin
            if (ha != 4'hf || lb[3]) begin status_image = ST_ADR; return; end
         end
         OP_PUSHL, OP_POPL, OP_READB, OP_READL, OP_WRITEB, OP_WRITEL: begin
            if (ha[3] || lb != 4'hf) begin status_image = ST_ADR; return; end
         end
         OP_JMP, OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL: begin
            if (tgt < code_start_q || tgt > code_end_q) begin
               status_image = ST_ADR;
               return;
            end
         end
         OP_RET: ;
         default: begin status_image = ST_INS; return; end
      endcase
      hi = ha[2:0];
      lo = lb[2:0];
      case (op)
         OP_RRMOVL: begin reg_image[lo] = reg_image[hi]; pc += 2; end
         OP_IRMOVL: begin reg_image[lo] = disp; pc += 6; end
         OP_RMMOVL: begin mem_wr32(disp + reg_image[lo], reg_image[hi]); pc += 6; end
         OP_MRMOVL: begin reg_image[hi] = mem_rd32(disp + reg_image[lo]); pc += 6; end
         OP_MOVSBL: begin
            v = {{24{1'b0}}, mem_rd8(disp + reg_image[lo])};
            reg_image[hi] = {{24{v[7]}}, v[7:0]};
            pc += 6;
         end
         OP_ADDL, OP_SUBL, OP_MULL, OP_CMPL: begin
            a64 = $signed(reg_image[hi]);
            b64 = $signed(reg_image[lo]);
            r64 = (op == OP_ADDL) ? b64 + a64 : (op == OP_MULL) ? b64 * a64 : b64 - a64;
            if (r64[63:31] != '0 && r64[63:31] != '1) begin
               zf_image = 1'b0; sf_image = 1'b0; of_image = 1'b1;
               status_image = ST_OVF;
               return;
            end
            v = r64[31:0];
            zf_image = (v == 0); sf_image = v[31]; of_image = 1'b0;
            if (op != OP_CMPL) reg_image[lo] = v;
            pc += 2;
         end
         OP_ANDL, OP_XORL: begin
            v = (op == OP_ANDL) ? (reg_image[lo] & reg_image[hi])
                                : (reg_image[lo] ^ reg_image[hi]);
            zf_image = (v == 0); sf_image = v[31]; of_image = 1'b0;
            reg_image[lo] = v;
            pc += 2;
         end
         OP_JMP, OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG: begin
            case (op)
               OP_JMP:  take = 1'b1;
               OP_JLE:  take = (sf_image != of_image) || zf_image;
               OP_JL:   take = (sf_image != of_image);
               OP_JE:   take = zf_image;
               OP_JNE:  take = !zf_image;
               OP_JGE:  take = (sf_image == of_image);
               default: take = (sf_image == of_image) && !zf_image;
            endcase
            pc = take ? tgt : pc + 5;
         end
         OP_CALL: begin
            reg_image[SP_REG] -= 4;
            v = pc + 5;
            mem_wr32(reg_image[SP_REG], {20'd0, v[11:0]});
            pc = tgt;
         end
         OP_RET: begin
            pc = mem_rd32(reg_image[SP_REG]);
            reg_image[SP_REG] += 4;
         end
         OP_PUSHL: begin
            v = reg_image[hi];
            reg_image[SP_REG] -= 4;
            mem_wr32(reg_image[SP_REG], v);
            pc += 2;
         end
         OP_POPL: begin
            v = mem_rd32(reg_image[SP_REG]);
            reg_image[SP_REG] += 4;
            reg_image[hi] = v;
            pc += 2;
         end
         OP_READB, OP_READL: begin
            if (r.input_present) begin
               addr = disp + reg_image[hi];
               v = r.input_value;
               if (op == OP_READB) begin
                  if (addr[11:0] < code_end_q) begin status_image = ST_ADR; return; end
                  v = v & 32'hff;
                  mem_image[addr[11:0]] = v[7:0];
               end else begin
                  mem_wr32(addr, v);
               end
               zf_image = (v == 0);
            end else begin
               zf_image = 1'b1;
            end
            pc += 6;
         end
         default: begin
            addr = disp + reg_image[hi];
            out_valid_n = 1'b1;
            out_byte_n = (op == OP_WRITEB);
            out_value_n = (op == OP_WRITEB) ? {24'd0, mem_rd8(addr)} : mem_rd32(addr);
            pc += 6;
         end
      endcase
      pc_image = pc[11:0];
   endfunction

   // Advance the model by one transaction and return the result it causes
   function automatic y86_rsp_type predict_result(y86_req_type r);
      y86_rsp_type p;
      out_valid_n = 1'b0;
      out_byte_n = 1'b0;
      out_value_n = '0;
      if (r.action == ACT_LOAD) mem_image[r.load_address] = r.load_byte;
      else if (r.action == ACT_START) begin
         pc_image = code_start_q;
         status_image = ST_OK;
      end else if (r.action == ACT_EXEC && status_image == ST_OK) execute_instr(r);
      p.status = status_image;
      p.program_counter = pc_image;
      p.out_valid = out_valid_n;
      p.out_is_byte = out_byte_n;
      p.out_value = out_value_n;
      p.zero_flag = zf_image;
      p.sign_flag = sf_image;
      p.overflow_flag = of_image;
      return p;
   endfunction

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      y86_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.status !== e.status || rsp_data.program_counter !== e.program_counter
                || rsp_data.out_valid !== e.out_valid || rsp_data.out_is_byte !== e.out_is_byte
                || rsp_data.out_value !== e.out_value || rsp_data.zero_flag !== e.zero_flag
                || rsp_data.sign_flag !== e.sign_flag
                || rsp_data.overflow_flag !== e.overflow_flag) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: st %0d/%0d pc %h/%h out %b%b %h/%b%b %h zso %b%b%b/%b%b%b",
                           e.status, rsp_data.status, e.program_counter,
                           rsp_data.program_counter, e.out_valid, e.out_is_byte, e.out_value,
                           rsp_data.out_valid, rsp_data.out_is_byte, rsp_data.out_value,
                           e.zero_flag, e.sign_flag, e.overflow_flag, rsp_data.zero_flag,
                           rsp_data.sign_flag, rsp_data.overflow_flag);
            end
         end
      end
   end

   // Stall the result channel at random while idle_on is set
   always @(negedge clock) begin
      rsp_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(y86_req_type r);
      if (idle_on && $urandom_range(99) < 34) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_result(r));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_action(logic [1:0] act, logic present = 1'b1);
      y86_req_type r;
      r.action = act;
      r.load_address = $urandom_range(MEM_SIZE - 1);
      r.load_byte = $urandom_range(255);
      case ($urandom_range(5))
         0: r.input_value = 32'h8000_0000;
         1: r.input_value = 32'h7fff_ffff;
         2: r.input_value = 0;
         3: r.input_value = $urandom_range(255);
         default: r.input_value = $urandom;
      endcase
      r.input_present = present;
      send_item(r);
   endtask

   task automatic load_mem(logic [11:0] a, logic [7:0] b);
      y86_req_type r;
      r = '0;
      r.action = ACT_LOAD;
      r.load_address = a;
      r.load_byte = b;
      send_item(r);
   endtask

   // Wait out all pending results, then hold until the core is idle
   task automatic drain();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [11:0] val);
      drain();
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_CODE_START) code_start_q = val;
      else code_end_q = val;
   endtask

   task automatic load_program(int base);
      foreach (program_bytes[i]) load_mem(base + i, program_bytes[i]);
   endtask

   function automatic void put_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) program_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic logic [3:0] pick_reg();
      if ($urandom_range(99) < 4) return $urandom_range(15);
      return $urandom_range(7);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(6))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 0;
         4: return $urandom_range(20);
         default: return $urandom;
      endcase
   endfunction

   // Append one random instruction to the program image
   function automatic void emit_instr(int base);
      logic [7:0] ops [28] = '{OP_NOP, OP_HALT, OP_RRMOVL, OP_IRMOVL, OP_RMMOVL, OP_MRMOVL,
                               OP_ADDL, OP_SUBL, OP_ANDL, OP_XORL, OP_MULL, OP_CMPL, OP_JMP,
                               OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL, OP_RET,
                               OP_PUSHL, OP_POPL, OP_READB, OP_READL, OP_WRITEB, OP_WRITEL,
                               OP_MOVSBL};
      logic [7:0]  op;
      logic [3:0]  fill;
      logic [31:0] tgt;
      fill = ($urandom_range(99) < 4) ? $urandom_range(15) : 4'hf;
      op = (ops[$urandom_range(27)] == OP_HALT && $urandom_range(3) != 0) ? OP_NOP
                                                                          : ops[$urandom_range(27)];
      if ($urandom_range(99) < 2) op = $urandom_range(255);
      instr_offsets.push_back(program_bytes.size());
      program_bytes.push_back(op);
      case (op)
         OP_NOP, OP_HALT, OP_RET: ;
         OP_RRMOVL, OP_ADDL, OP_SUBL, OP_ANDL, OP_XORL, OP_MULL, OP_CMPL:
            program_bytes.push_back({pick_reg(), pick_reg()});
         OP_PUSHL, OP_POPL: program_bytes.push_back({pick_reg(), fill});
         OP_IRMOVL: begin
            program_bytes.push_back({fill, pick_reg()});
            put_word(pick_value());
         end
         OP_RMMOVL, OP_MRMOVL, OP_MOVSBL: begin
            program_bytes.push_back({pick_reg(), pick_reg()});
            put_word($urandom_range(99) < 80 ? $urandom_range(MEM_SIZE - 1) : $urandom);
         end
         OP_READB, OP_READL, OP_WRITEB, OP_WRITEL: begin
            program_bytes.push_back({pick_reg(), fill});
            put_word($urandom_range(99) < 80 ? 32'hc00 + $urandom_range(255) : $urandom);
         end
         OP_JMP, OP_JLE, OP_JL, OP_JE, OP_JNE, OP_JGE, OP_JG, OP_CALL: begin
            if ($urandom_range(99) < 8) tgt = $urandom;
            else if ($urandom_range(99) < 15) tgt = base + program_bytes.size() + 4;
            else tgt = base + instr_offsets[$urandom_range(instr_offsets.size() - 1)];
            put_word(tgt);
         end
         default: program_bytes.push_back($urandom_range(255));
      endcase
   endfunction

   task automatic test_empty_region();
      write_csr(CSR_CODE_START, 12'd0);
      write_csr(CSR_CODE_END, 12'd0);
      send_action(ACT_EXEC);
      send_action(ACT_START);
      send_action(2'd3);
      load_mem(12'hfff, 8'hff);
      load_mem(12'h000, 8'h00);
      write_csr(CSR_CODE_START, 12'hfff);
      write_csr(CSR_CODE_END, 12'hfff);
      send_action(ACT_START);
      send_action(ACT_EXEC);
   endtask

   task automatic test_before_code();
      write_csr(CSR_CODE_START, 12'd100);
      write_csr(CSR_CODE_END, 12'd200);
      send_action(ACT_START);
      write_csr(CSR_CODE_START, 12'd150);
      send_action(ACT_EXEC);
      send_action(ACT_EXEC);
   endtask

   task automatic test_overflow_and_output();
      program_bytes = '{};
      program_bytes.push_back(OP_IRMOVL); program_bytes.push_back(8'hf1);
      put_word(32'h7fff_ffff);
      program_bytes.push_back(OP_WRITEL); program_bytes.push_back(8'h1f); put_word(32'h8000_0001);
      program_bytes.push_back(OP_READL); program_bytes.push_back(8'h1f); put_word(32'h8000_0c01);
      program_bytes.push_back(OP_ADDL); program_bytes.push_back(8'h11);
      write_csr(CSR_CODE_START, 12'd16);
      write_csr(CSR_CODE_END, 12'd16 + program_bytes.size());
      load_program(16);
      send_action(ACT_START);
      send_action(ACT_EXEC);
      send_action(ACT_EXEC);
      send_action(ACT_EXEC, 1'b0);
      send_action(ACT_EXEC);
      send_action(ACT_EXEC);
   endtask

   // Random programs, each run from a restart with noise mixed in
   task automatic test_random_programs();
      int base, phase, pick;
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         idle_on = !(phase >= 3 && phase < 6);
         base = (phase == 1) ? 0 : $urandom_range(0, 2400);
         program_bytes = '{};
         instr_offsets = '{};
         program_bytes.push_back(OP_IRMOVL); program_bytes.push_back({4'hf, SP_REG});
         put_word(32'hb00 + 4 * $urandom_range(0, 60));
         instr_offsets.push_back(0);
         repeat ($urandom_range(8, 20)) emit_instr(base);
         write_csr(CSR_CODE_START, base);
         write_csr(CSR_CODE_END, (phase == 1) ? 12'hfff : base + program_bytes.size());
         load_program(base);
         send_action(ACT_START);
         repeat (60) begin
            pick = $urandom_range(99);
            if (pick < 5) send_action(ACT_LOAD);
            else if (pick < 7) send_action(2'd3);
            else if (pick < 9 || (status_image != ST_OK && pick < 50)) send_action(ACT_START);
            else send_action(ACT_EXEC, $urandom_range(99) < 85);
         end
         // in phase 2, hold the sender until every result is back
         if (phase == 2) drain();
         phase++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      foreach (mem_image[i]) mem_image[i] = '0;
      foreach (reg_image[i]) reg_image[i] = '0;
      pc_image = '0;
      {zf_image, sf_image, of_image} = '0;
      status_image = ST_OK;
      code_start_q = '0;
      code_end_q = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_region();
      test_before_code();
      test_overflow_and_output();
      test_random_programs();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
